/* sv/fpd_pkg.sv */
// package: fuzzy pd controller types, tables and constants
package fpd_pkg;

    localparam int ErrW  = 17;
    localparam int ChgW  = 18;
    localparam int SetPoints = 3;

    typedef enum logic [2:0] {
        t_st_idle,
        t_st_fuzz,
        t_st_rule,
        t_st_sum,
        t_st_div,
        t_st_done
    } t_state;

    // breakpoints in q8.8 for error sets
    function automatic logic signed [ChgW-1:0] err_pt(input logic [2:0] s, input logic [1:0] p);
        logic signed [ChgW-1:0] v;
        v = '0;
        case ({s, p})
            {3'd0, 2'd0}: v = -18'sd3840;
            {3'd0, 2'd1}: v = -18'sd512;
            {3'd0, 2'd2}: v = -18'sd128;
            {3'd1, 2'd0}: v = -18'sd512;
            {3'd1, 2'd1}: v = -18'sd128;
            {3'd1, 2'd2}: v = 18'sd0;
            {3'd2, 2'd0}: v = -18'sd128;
            {3'd2, 2'd1}: v = 18'sd0;
            {3'd2, 2'd2}: v = 18'sd128;
            {3'd3, 2'd0}: v = 18'sd0;
            {3'd3, 2'd1}: v = 18'sd128;
            {3'd3, 2'd2}: v = 18'sd512;
            {3'd4, 2'd0}: v = 18'sd128;
            {3'd4, 2'd1}: v = 18'sd512;
            {3'd4, 2'd2}: v = 18'sd3840;
            default:      v = '0;
        endcase
        return v;
    endfunction

    function automatic logic err_lv(input logic [2:0] s, input logic [1:0] p);
        logic v;
        v = 1'b0;
        case ({s, p})
            {3'd0, 2'd0}, {3'd0, 2'd1}: v = 1'b1;
            {3'd1, 2'd1}, {3'd2, 2'd1}, {3'd3, 2'd1}: v = 1'b1;
            {3'd4, 2'd1}, {3'd4, 2'd2}: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ChgW-1:0] rate_pt(input logic [2:0] s, input logic [1:0] p);
        return err_pt(s + 3'd1, p);
    endfunction

    function automatic logic rate_lv(input logic [2:0] s, input logic [1:0] p);
        logic v;
        v = 1'b0;
        case ({s, p})
            {3'd0, 2'd0}, {3'd0, 2'd1}: v = 1'b1;
            {3'd1, 2'd1}: v = 1'b1;
            {3'd2, 2'd1}, {3'd2, 2'd2}: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] rule_out(input logic [2:0] i, input logic [2:0] j);
        logic [2:0] v;
        v = 3'd2;
        case ({i, j})
            {3'd0, 3'd0}: v = 3'd4;
            {3'd0, 3'd1}: v = 3'd3;
            {3'd0, 3'd2}: v = 3'd3;
            {3'd1, 3'd0}: v = 3'd4;
            {3'd1, 3'd1}: v = 3'd3;
            {3'd1, 3'd2}: v = 3'd2;
            {3'd3, 3'd0}: v = 3'd2;
            {3'd3, 3'd1}: v = 3'd1;
            {3'd3, 3'd2}: v = 3'd0;
            {3'd4, 3'd0}: v = 3'd1;
            {3'd4, 3'd1}: v = 3'd1;
            {3'd4, 3'd2}: v = 3'd0;
            default:      v = 3'd2;
        endcase
        return v;
    endfunction

endpackage

/* sv/fuzzy_pd_controller.sv */
// top level: fuzzy pd controller with max-min rules and singleton defuzzification
// Usage:
//   input channel i_measured_temp_valid/o_measured_temp_ready takes one
//   signed q8.8 sample per beat. The user must write setpoint (reset value 22.0)
//   via i_cfg_we and i_cfg_wdata only while idle; the block does not enforce it.
//   output channel o_drive_valid/i_drive_ready returns one beat per sample:
//   o_drive (signed q3.8, -2..2) and o_no_rule_fired.
// Each sample passes through grading of the eight fuzzy sets (one fuzzy
// set per cycle), the 15 rules through a shared min/max unit, the
// accumulation of the five levels, a serial divider with one quotient
// bit per cycle, and the hand-over to the output register. With no rule
// fired the divider is skipped. A new sample is taken in the cycle after
// the result is loaded, so the block never works on two samples at once.
// A stalled receiver holds the output register; the next sample is still
// worked on and waits at the end until the held beat leaves.
// Reset clears the previous error, restores the setpoint and empties the
// output register.
module fuzzy_pd_controller #(
    parameter int MEMBERSHIP_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic signed [15:0]  i_cfg_wdata,
    input  logic                i_measured_temp_valid,
    output logic                o_measured_temp_ready,
    input  logic signed [15:0]  i_measured_temp,
    output logic                o_drive_valid,
    input  logic                i_drive_ready,
    output logic signed [10:0]  o_drive,
    output logic                o_no_rule_fired
);
    import fpd_pkg::*;

    localparam int MbW   = MEMBERSHIP_BITS;
    localparam int DenW  = MbW + 3;
    localparam int NumW  = MbW + 14;
    localparam logic [MbW-1:0] Full = {MbW{1'b1}};
    localparam int QW     = MbW + 5;
    localparam int K3     = MbW + 4;
    localparam int K26    = MbW + 10;
    localparam int Recip3  = (2 ** K3 + 2) / 3;
    localparam int Recip26 = (2 ** K26 + 25) / 26;
    localparam logic signed [NumW:0] Lvl1 = 256;
    localparam logic signed [NumW:0] Lvl2 = 512;

    t_state r_state, n_state;
    logic signed [15:0]     r_setpoint;
    logic signed [ErrW-1:0] r_prev_err;
    logic signed [ErrW-1:0] r_err;
    logic signed [ChgW-1:0] r_chg;
    logic [MbW-1:0] r_ge [5];
    logic [MbW-1:0] r_gr [3];
    logic [MbW-1:0] r_str [5];
    logic [2:0] r_i, r_j;
    logic signed [NumW:0] r_num;
    logic [DenW-1:0]      r_den;
    logic r_out_valid;
    logic signed [10:0] r_drive;
    logic r_nrf;

    // grading of one set per cycle
    logic               w_is_err;
    logic [2:0]         w_set;
    logic signed [ChgW-1:0] w_x, w_a, w_b, w_c;
    logic w_la, w_lb, w_lc;
    logic [MbW-1:0] w_grade;
    logic signed [ChgW-1:0] w_p0, w_p1;
    logic w_u0, w_u1;
    logic [ChgW+MbW-1:0] w_prod;
    logic [ChgW-1:0] w_span, w_off;
    logic [MbW-1:0] w_interp;
    logic [QW-1:0] w_q7;
    logic [QW+K3-1:0] w_m3;
    logic [QW+K26-1:0] w_m26;

    always_comb begin
        w_is_err = (r_i < 3'd5);
        w_set = w_is_err ? r_i : r_i - 3'd5;
        w_x  = w_is_err ? ChgW'(r_err) : r_chg;
        w_a  = w_is_err ? err_pt(w_set, 2'd0) : rate_pt(w_set, 2'd0);
        w_b  = w_is_err ? err_pt(w_set, 2'd1) : rate_pt(w_set, 2'd1);
        w_c  = w_is_err ? err_pt(w_set, 2'd2) : rate_pt(w_set, 2'd2);
        w_la = w_is_err ? err_lv(w_set, 2'd0) : rate_lv(w_set, 2'd0);
        w_lb = w_is_err ? err_lv(w_set, 2'd1) : rate_lv(w_set, 2'd1);
        w_lc = w_is_err ? err_lv(w_set, 2'd2) : rate_lv(w_set, 2'd2);
        if (w_x <= w_b) begin
            w_p0 = w_a; w_p1 = w_b; w_u0 = w_la; w_u1 = w_lb;
        end else begin
            w_p0 = w_b; w_p1 = w_c; w_u0 = w_lb; w_u1 = w_lc;
        end
        w_span = ChgW'(w_p1 - w_p0);
        w_off  = w_u1 ? ChgW'(w_x - w_p0) : ChgW'(w_p1 - w_x);
        // spans are 128, 384 or 3328: shift by 7, then reciprocal for 3 or 26
        w_prod = (ChgW+MbW)'(w_off) * (ChgW+MbW)'(Full);
        w_q7   = QW'(w_prod >> 7);
        w_m3   = (QW+K3)'(w_q7) * (QW+K3)'(Recip3);
        w_m26  = (QW+K26)'(w_q7) * (QW+K26)'(Recip26);
        case (w_span)
            ChgW'(128): w_interp = MbW'(w_q7);
            ChgW'(384): w_interp = MbW'(w_m3 >> K3);
            default:    w_interp = MbW'(w_m26 >> K26);
        endcase
        if (w_x < w_a) begin
            w_grade = w_la ? Full : '0;
        end else if (w_x > w_c) begin
            w_grade = w_lc ? Full : '0;
        end else if (w_u0 == w_u1) begin
            w_grade = w_u0 ? Full : '0;
        end else begin
            w_grade = w_interp;
        end
    end

    // shared min/max for rules
    logic [MbW-1:0] w_min;
    logic [2:0] w_k;
    assign w_min = (r_ge[r_i] < r_gr[r_j[1:0]]) ? r_ge[r_i] : r_gr[r_j[1:0]];
    assign w_k = rule_out(r_i, r_j);

    // accumulation of one level per cycle
    logic signed [NumW:0] w_term;
    always_comb begin
        case (r_i)
            3'd0: w_term = -((NumW+1)'($signed({1'b0, r_str[0]})) * Lvl2);
            3'd1: w_term = -((NumW+1)'($signed({1'b0, r_str[1]})) * Lvl1);
            3'd3: w_term = (NumW+1)'($signed({1'b0, r_str[3]})) * Lvl1;
            3'd4: w_term = (NumW+1)'($signed({1'b0, r_str[4]})) * Lvl2;
            default: w_term = '0;
        endcase
    end

    logic div_start, div_done;
    logic [NumW-1:0] div_num, div_quo;
    logic [NumW-1:0] w_mag;
    assign w_mag = r_num[NumW] ? NumW'(-r_num) : NumW'(r_num);
    assign div_num = w_mag + NumW'(r_den >> 1);

    fpd_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_st_idle: if (i_measured_temp_valid && o_measured_temp_ready) n_state = t_st_fuzz;
            t_st_fuzz: if (r_i == 3'd7) n_state = t_st_rule;
            t_st_rule: if (r_i == 3'd4 && r_j == 3'd2) n_state = t_st_sum;
            t_st_sum:  if (r_i == 3'd5) n_state = (r_den == '0) ? t_st_done : t_st_div;
            t_st_div:  if (div_done) n_state = t_st_done;
            t_st_done: if (!r_out_valid || i_drive_ready) n_state = t_st_idle;
            default:   n_state = t_st_idle;
        endcase
    end

    always_comb begin
        o_measured_temp_ready = (r_state == t_st_idle);
        div_start = (r_state == t_st_sum) && (r_i == 3'd5) && (r_den != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= t_st_idle;
            r_setpoint  <= 16'sd5632;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
            r_i <= '0;
            r_j <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_setpoint <= i_cfg_wdata;
            if (o_drive_valid && i_drive_ready && r_state != t_st_done) r_out_valid <= 1'b0;
            case (r_state)
                t_st_idle: begin
                    if (i_measured_temp_valid) begin
                        r_err <= ErrW'(i_measured_temp) - ErrW'(r_setpoint);
                        r_chg <= ChgW'(ErrW'(i_measured_temp) - ErrW'(r_setpoint))
                               - ChgW'(r_prev_err);
                        r_prev_err <= ErrW'(i_measured_temp) - ErrW'(r_setpoint);
                        r_i <= '0;
                    end
                end
                t_st_fuzz: begin
                    if (w_is_err) r_ge[r_i] <= w_grade;
                    else r_gr[w_set[1:0]] <= w_grade;
                    r_i <= (r_i == 3'd7) ? 3'd0 : r_i + 3'd1;
                    r_j <= '0;
                    for (int k = 0; k < 5; k++) r_str[k] <= '0;
                end
                t_st_rule: begin
                    if (w_min > r_str[w_k]) r_str[w_k] <= w_min;
                    if (r_j == 3'd2) begin
                        r_j <= '0;
                        r_i <= (r_i == 3'd4) ? 3'd0 : r_i + 3'd1;
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                    r_num <= '0;
                    r_den <= '0;
                end
                t_st_sum: begin
                    // last cycle only hands the finished sums on
                    if (r_i != 3'd5) begin
                        r_num <= r_num + w_term;
                        r_den <= r_den + DenW'(r_str[r_i]);
                        r_i <= r_i + 3'd1;
                    end
                end
                t_st_done: begin
                    if (!r_out_valid || i_drive_ready) begin
                        r_out_valid <= 1'b1;
                        r_nrf <= (r_den == '0);
                        if (r_den == '0) r_drive <= '0;
                        else if (r_num[NumW]) r_drive <= -11'(div_quo);
                        else r_drive <= 11'(div_quo);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_drive_valid   = r_out_valid;
    assign o_drive         = r_drive;
    assign o_no_rule_fired = r_nrf;
endmodule

/* sv/fpd_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module fpd_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CntW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = CntW'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* dv/tb_fuzzy_pd_controller.sv */
// testbench: fuzzy pd controller checked against a max-min singleton predictor
`timescale 1ns / 100ps

module tb_fuzzy_pd_controller;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic signed [15:0]  i_cfg_wdata = '0;
    logic                i_measured_temp_valid = 1'b0;
    logic                o_measured_temp_ready;
    logic signed [15:0]  i_measured_temp = '0;
    logic                o_drive_valid;
    logic                i_drive_ready = 1'b0;
    logic signed [10:0]  o_drive;
    logic                o_no_rule_fired;

    localparam int FullGrade  = 255;
    localparam int DrainWait  = 80;
    localparam int CycleLimit = 500000;

    typedef struct {
        logic signed [10:0] drive;
        logic               idle_flag;
    } drive_beat_t;

    typedef struct {
        bit                 is_setpoint;
        logic signed [15:0] value;
        bit                 typed;
        logic signed [10:0] drive;
        logic               idle_flag;
    } stim_row_t;

    // breakpoints and end levels of the error and rate sets
    int err_pts [5][3] = '{'{-3840, -512, -128}, '{-512, -128, 0}, '{-128, 0, 128},
                           '{0, 128, 512}, '{128, 512, 3840}};
    bit err_lvl [5][3] = '{'{1, 1, 0}, '{0, 1, 0}, '{0, 1, 0}, '{0, 1, 0}, '{0, 1, 1}};
    int rate_pts[3][3] = '{'{-512, -128, 0}, '{-128, 0, 128}, '{0, 128, 512}};
    bit rate_lvl[3][3] = '{'{1, 1, 0}, '{0, 1, 0}, '{0, 1, 1}};
    int level_q88[5]   = '{-512, -256, 0, 256, 512};
    int rule_level[5][3] = '{'{4, 3, 3}, '{4, 3, 2}, '{2, 2, 2}, '{2, 1, 0}, '{1, 1, 0}};

    int          pred_setpoint = 5632;
    longint      pred_prev_err = 0;
    drive_beat_t pending_drives[$];
    int          errors = 0;
    int          ready_stall = 0;
    bit          steady_mode = 0;
    int          cycles = 0;

    fuzzy_pd_controller u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_measured_temp_valid (i_measured_temp_valid),
        .o_measured_temp_ready (o_measured_temp_ready),
        .i_measured_temp       (i_measured_temp),
        .o_drive_valid         (o_drive_valid),
        .i_drive_ready         (i_drive_ready),
        .o_drive               (o_drive),
        .o_no_rule_fired       (o_no_rule_fired)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint set_grade(longint x, int p0, int p1, int p2,
                                         bit l0, bit l1, bit l2);
        longint pts[3];
        longint lv[3];
        pts = '{p0, p1, p2};
        lv  = '{l0 ? FullGrade : 0, l1 ? FullGrade : 0, l2 ? FullGrade : 0};
        if (x < pts[0]) return lv[0];
        for (int i = 0; i < 2; i++) begin
            if (x >= pts[i] && x <= pts[i+1]) begin
                if (pts[i+1] == pts[i] || lv[i] == lv[i+1]) return lv[i];
                if (lv[i] < lv[i+1])
                    return lv[i] + (x - pts[i]) * (lv[i+1] - lv[i]) / (pts[i+1] - pts[i]);
                return lv[i+1] + (pts[i+1] - x) * (lv[i] - lv[i+1]) / (pts[i+1] - pts[i]);
            end
        end
        return lv[2];
    endfunction

    // infers one drive beat and advances the stored error
    function automatic drive_beat_t infer_drive(logic signed [15:0] temp);
        drive_beat_t r;
        longint e, c, w, num, den, q, mag;
        longint ge[5];
        longint gr[3];
        longint strength[5];
        e = longint'(temp) - pred_setpoint;
        c = e - pred_prev_err;
        num = 0;
        den = 0;
        for (int i = 0; i < 5; i++) begin
            ge[i] = set_grade(e, err_pts[i][0], err_pts[i][1], err_pts[i][2],
                              err_lvl[i][0], err_lvl[i][1], err_lvl[i][2]);
            strength[i] = 0;
        end
        for (int j = 0; j < 3; j++)
            gr[j] = set_grade(c, rate_pts[j][0], rate_pts[j][1], rate_pts[j][2],
                              rate_lvl[j][0], rate_lvl[j][1], rate_lvl[j][2]);
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 3; j++) begin
                w = ge[i] < gr[j] ? ge[i] : gr[j];
                if (w > strength[rule_level[i][j]]) strength[rule_level[i][j]] = w;
            end
        for (int i = 0; i < 5; i++) begin
            num += level_q88[i] * strength[i];
            den += strength[i];
        end
        q = 0;
        if (den > 0) begin
            mag = num < 0 ? -num : num;
            q = (mag + den / 2) / den;
            if (num < 0) q = -q;
        end
        pred_prev_err = e;
        r.drive = q[10:0];
        r.idle_flag = (den == 0);
        return r;
    endfunction

    // one input beat; valid held until accepted
    task automatic send_temp(logic signed [15:0] temp, bit typed, drive_beat_t typed_exp);
        int gap;
        drive_beat_t pred;
        gap = steady_mode ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_measured_temp_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_measured_temp_valid <= 1'b1;
        i_measured_temp <= temp;
        pred = infer_drive(temp);
        pending_drives.push_back(typed ? typed_exp : pred);
        do @(posedge i_clk); while (!o_measured_temp_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_measured_temp_valid <= 1'b0;
        wait (pending_drives.size() == 0);
        repeat (DrainWait) @(negedge i_clk);
    endtask

    task automatic write_setpoint(logic signed [15:0] sp);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= sp;
        pred_setpoint = sp;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] near_temp(int center, int spread);
        int v;
        v = center + $signed($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // result side
    always @(posedge i_clk) begin
        drive_beat_t exp_beat;
        if (i_rst_n && o_drive_valid && i_drive_ready) begin
            if (pending_drives.size() == 0) begin
                $display("%0t: unexpected drive beat drive=%0d flag=%0b",
                         $time, o_drive, o_no_rule_fired);
                errors++;
            end else begin
                exp_beat = pending_drives.pop_front();
                if (o_drive !== exp_beat.drive) begin
                    $display("%0t: drive expected %0d actual %0d",
                             $time, exp_beat.drive, o_drive);
                    errors++;
                end
                if (o_no_rule_fired !== exp_beat.idle_flag) begin
                    $display("%0t: no_rule_fired expected %0b actual %0b",
                             $time, exp_beat.idle_flag, o_no_rule_fired);
                    errors++;
                end
            end
            ready_stall = steady_mode ? 0 : $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        i_drive_ready <= (ready_stall == 0);
        if (ready_stall > 0) ready_stall--;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("tb_fuzzy_pd_controller: done, errors");
            $finish;
        end
    end

    stim_row_t directed[$] = '{
        '{0, 16'sd5632,   1, 11'sd0,    1'b0},   // error and change both zero
        '{0, -16'sd32768, 1, 11'sd512,  1'b0},   // far below, falling hard
        '{0, 16'sd32767,  1, -11'sd512, 1'b0},   // far above, rising hard
        '{0, 16'sd5632 - 16'sd3840, 0, 0, 0},
        '{0, 16'sd5632 - 16'sd512,  0, 0, 0},
        '{0, 16'sd5632 - 16'sd129,  0, 0, 0},
        '{0, 16'sd5632 - 16'sd128,  0, 0, 0},
        '{0, 16'sd5632,             0, 0, 0},
        '{0, 16'sd5632 + 16'sd128,  0, 0, 0},
        '{0, 16'sd5632 + 16'sd512,  0, 0, 0},
        '{0, 16'sd5632 + 16'sd3840, 0, 0, 0},
        '{0, 16'sd5632 + 16'sd4000, 0, 0, 0},
        '{1, -16'sd32768, 0, 0, 0},
        '{0, 16'sd32767,  0, 0, 0},
        '{0, -16'sd32768, 0, 0, 0},
        '{1, 16'sd32767,  0, 0, 0},
        '{0, -16'sd32768, 0, 0, 0},
        '{0, 16'sd32767,  0, 0, 0},
        '{1, 16'sd0,      0, 0, 0},
        '{0, 16'sd0,      0, 0, 0},
        '{0, 16'sd200,    0, 0, 0},
        '{0, -16'sd300,   0, 0, 0}
    };

    initial begin
        drive_beat_t typed_exp;
        logic signed [15:0] sp;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[n]) begin
            if (directed[n].is_setpoint) begin
                write_setpoint(directed[n].value);
            end else begin
                typed_exp.drive = directed[n].drive;
                typed_exp.idle_flag = directed[n].idle_flag;
                send_temp(directed[n].value, directed[n].typed, typed_exp);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: sp = 16'sd5632;
                1: sp = -16'sd32768;
                2: sp = 16'sd32767;
                default: sp = 16'($urandom_range(0, 65535));
            endcase
            write_setpoint(sp);
            steady_mode = (ph == 3);
            for (int k = 0; k < 250; k++) begin
                // mostly samples that walk around the setpoint, some wild ones
                if ($urandom_range(0, 9) < 7)
                    send_temp(near_temp(sp, ($urandom_range(0, 3) == 0) ? 4000 : 700),
                              0, typed_exp);
                else
                    send_temp(16'($urandom_range(0, 65535)), 0, typed_exp);
            end
        end
        drain();

        if (errors == 0)
            $display("tb_fuzzy_pd_controller: done, clean");
        else
            $display("tb_fuzzy_pd_controller: done, errors");
        $finish;
    end

endmodule
